@@ rtl/fwt_pkg.sv @@
// ----------------------------------------------------------------------------
// fwt_pkg
// Shared widths, request codes and sequencer states for the Fenwick tree core.
// ----------------------------------------------------------------------------
package fwt_pkg;

  localparam int TYPE_W  = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 11;
  localparam int SUM_W   = 32;

  localparam logic [TYPE_W-1:0] REQ_INC   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_BUILD = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_RD,
    ST_UP_WR,
    ST_Q_RUN,
    ST_Q_DONE
  } state_t;

endpackage

@@ rtl/fwt_if.sv @@
// ----------------------------------------------------------------------------
// fwt_if
// Valid/ready channels: request channel and range-sum response channel.
// ----------------------------------------------------------------------------
interface fwt_req_if;
  import fwt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         req_type;
  logic [INDEX_W-1:0]        first_index;
  logic [INDEX_W-1:0]        last_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, req_type, first_index, last_index, value, input ready);
  modport sink   (input valid, req_type, first_index, last_index, value, output ready);
endinterface

interface fwt_rsp_if;
  import fwt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;
  logic                    status;

  modport source (output valid, range_sum, status, input ready);
  modport sink   (input valid, range_sum, status, output ready);
endinterface

@@ rtl/fwt_ram.sv @@
// ----------------------------------------------------------------------------
// fwt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fwt_alu.sv @@
// ----------------------------------------------------------------------------
// fwt_alu
// Shared wrapping adder/subtractor used by both update and query walks.
// ----------------------------------------------------------------------------
module fwt_alu #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] y
);

  always_comb begin
    if (sub) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end

endmodule

@@ rtl/fenwick_range_sum_tree_core.sv @@
// ----------------------------------------------------------------------------
// fenwick_range_sum_tree_core
// Zero-based Fenwick tree: point increase, in-order build, range-sum query.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+----------------------------------------------
//  req      | in  | valid/ready | req_type, first_index, last_index, value
//  rsp      | out | valid/ready | range_sum, status (query only)
//  cfg      | in  | cfg_we      | cfg_wdata = active_size
//
//  Increase: per node of the i|(i+1) chain, a RAM read, then add and write.
//  Build: updates at most two nodes. Query: one RAM read per node over both
//  prefix chains. req.ready is high only when idle.
//  After reset a clearing pass writes CAPACITY entries, one per cycle.
//  A finished query waits in the sequencer while rsp holds an unread result.
// ----------------------------------------------------------------------------
module fenwick_range_sum_tree_core #(
  parameter int CAPACITY      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  fwt_req_if.sink                   req,
  fwt_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [fwt_pkg::SIZE_W-1:0] cfg_wdata
);
  import fwt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int EW = ELEMENT_WIDTH;
  localparam logic [PW-1:0] CAP_P  = PW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  state_t state, state_next;

  logic [SIZE_W-1:0] active_size;
  logic [PW-1:0]     size;
  logic [AW-1:0]     clr_addr;

  logic [PW-1:0] p;
  logic [EW-1:0] amt;
  logic          is_build;
  logic          build_first;

  logic [AW-1:0] e;
  logic          e_valid;
  logic          phase;
  logic          lo_needed;
  logic [AW-1:0] lo_start;
  logic          q_pend;
  logic          q_pend_sub;
  logic [EW-1:0] acc;
  logic          q_status;

  logic          rsp_valid;
  logic [SUM_W-1:0] rsp_sum;
  logic          rsp_status;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [EW-1:0] alu_a, alu_b, alu_y;
  logic          alu_sub;

  logic          req_fire;
  logic [PW-1:0] first_x, last_x, p_nx;
  logic [AW-1:0] e_and;
  logic          up_cont;
  logic          rsp_free;

  assign size     = ({{(PW-SIZE_W){1'b0}}, active_size} > CAP_P) ? CAP_P
                  : {{(PW-SIZE_W){1'b0}}, active_size};
  assign req_fire = req.valid && req.ready;
  assign first_x  = PW'(req.first_index);
  assign last_x   = PW'(req.last_index);
  assign p_nx     = p | (p + PW'(1));
  assign e_and    = e & (e + AW'(1));
  assign up_cont  = (p_nx < size) && (!is_build || build_first);
  assign rsp_free = !rsp_valid || rsp.ready;

  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.range_sum = rsp_sum;
  assign rsp.status    = rsp_status;

  fwt_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fwt_alu #(.WIDTH(EW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, RAM and ALU control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = p[AW-1:0];
    ram_wdata  = alu_y;
    ram_re     = 1'b0;
    ram_raddr  = p[AW-1:0];
    alu_a      = ram_rdata;
    alu_b      = amt;
    alu_sub    = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_A) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_INC, REQ_BUILD: begin
              if (first_x < size) begin
                state_next = ST_UP_RD;
              end
            end
            REQ_QUERY: begin
              if (first_x >= size || last_x >= size) begin
                state_next = ST_Q_DONE;
              end else begin
                state_next = ST_Q_RUN;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_UP_RD: begin
        ram_re     = 1'b1;
        state_next = ST_UP_WR;
      end
      ST_UP_WR: begin
        ram_we     = 1'b1;
        state_next = up_cont ? ST_UP_RD : ST_IDLE;
      end
      ST_Q_RUN: begin
        alu_a     = acc;
        alu_b     = ram_rdata;
        alu_sub   = q_pend_sub;
        ram_re    = e_valid;
        ram_raddr = e;
        if (!e_valid && !q_pend) begin
          state_next = ST_Q_DONE;
        end
      end
      ST_Q_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SIZE_RESET;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
      e_valid     <= 1'b0;
      q_pend      <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_size <= cfg_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_Q_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_IDLE && req_fire) begin
        e_valid <= 1'b1;
        q_pend  <= 1'b0;
      end else if (state == ST_Q_RUN) begin
        q_pend <= e_valid;
        if (e_valid && e_and == '0 && (phase || !lo_needed)) begin
          e_valid <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        p           <= first_x;
        amt         <= EW'(req.value);
        is_build    <= (req.req_type == REQ_BUILD);
        build_first <= 1'b1;
        e           <= AW'(req.last_index);
        phase       <= 1'b0;
        lo_needed   <= (req.first_index != '0);
        lo_start    <= AW'(req.first_index) - AW'(1);
        acc         <= '0;
        q_status    <= (first_x >= size || last_x >= size) ? STATUS_RANGE : STATUS_OK;
      end
      ST_UP_WR: begin
        p <= p_nx;
        if (is_build) begin
          amt         <= alu_y;
          build_first <= 1'b0;
        end
      end
      ST_Q_RUN: begin
        if (q_pend) begin
          acc <= alu_y;
        end
        if (e_valid) begin
          q_pend_sub <= phase;
          // prefix walk: e -> (e & (e+1)) - 1, then the lower bound chain
          if (e_and != '0) begin
            e <= e_and - AW'(1);
          end else if (!phase && lo_needed) begin
            phase <= 1'b1;
            e     <= lo_start;
          end
        end
      end
      ST_Q_DONE: begin
        if (rsp_free) begin
          rsp_sum    <= SUM_W'(acc);
          rsp_status <= q_status;
        end
      end
      default: begin
      end
    endcase
  end

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STATUS_RANGE |-> rsp.range_sum == '0)
    else $error("out-of-range query returned a nonzero sum");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_UP_WR |-> p < size)
    else $error("update chain wrote beyond the active size");

  a_build_two_nodes: assert property (@(posedge clk) disable iff (rst)
    state == ST_UP_WR && is_build && !build_first |=> state == ST_IDLE)
    else $error("build walked past the next node");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_Q_DONE)
    else $error("response raised outside query completion");

endmodule

@@ dv/fwt_range_sum_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwt_range_sum_checker
// Watches the request, response and config ports of the Fenwick tree core,
// keeps its own copy of the partial-sum store, predicts every range-sum
// response and compares each returned transaction against the oldest one due.
// ----------------------------------------------------------------------------
module fwt_range_sum_checker #(
  parameter int CAP = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  fwt_req_if                         req,
  fwt_rsp_if                         rsp,
  input  logic                       cfg_we,
  input  logic [fwt_pkg::SIZE_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  import fwt_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] range_sum;
    logic             status;
  } sum_rec_t;

  logic [SUM_W-1:0]  node_sums [CAP];
  logic [SIZE_W-1:0] size_reg;
  sum_rec_t          due_sums [$];
  int                errors = 0;

  function automatic int live_size();
    return (size_reg > CAP) ? CAP : int'(size_reg);
  endfunction

  // prefix walk: e -> (e & (e+1)) - 1
  function automatic logic [SUM_W-1:0] tree_prefix(int last);
    logic [SUM_W-1:0] acc;
    int e;
    acc = '0;
    e   = last;
    while (e >= 0) begin
      acc = acc + node_sums[e];
      e   = (e & (e + 1)) - 1;
    end
    return acc;
  endfunction

  task automatic tree_add(int pos, logic [SUM_W-1:0] amount);
    int p;
    p = pos;
    while (p < live_size()) begin
      node_sums[p] = node_sums[p] + amount;
      p = p | (p + 1);
    end
  endtask

  task automatic predict_request(logic [TYPE_W-1:0] kind, logic [INDEX_W-1:0] first,
                                 logic [INDEX_W-1:0] last, logic [VALUE_W-1:0] value);
    sum_rec_t rec;
    int       lim;
    int       nxt;
    lim = live_size();
    case (kind)
      REQ_INC: begin
        if (first < lim) tree_add(int'(first), value);
      end
      REQ_BUILD: begin
        if (first < lim) begin
          nxt = int'(first) | (int'(first) + 1);
          node_sums[first] = node_sums[first] + value;
          if (nxt < lim) node_sums[nxt] = node_sums[nxt] + node_sums[first];
        end
      end
      REQ_QUERY: begin
        if (first >= lim || last >= lim) begin
          rec.range_sum = '0;
          rec.status    = STATUS_RANGE;
        end else begin
          rec.range_sum = tree_prefix(int'(last)) - tree_prefix(int'(first) - 1);
          rec.status    = STATUS_OK;
        end
        due_sums.push_back(rec);
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(string what, sum_rec_t want, sum_rec_t got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected sum %h status %b, got sum %h status %b", $realtime,
               what, want.range_sum, want.status, got.range_sum, got.status);
  endtask

  always @(posedge clk) begin
    sum_rec_t want;
    sum_rec_t got;
    if (rst) begin
      for (int i = 0; i < CAP; i++) node_sums[i] = '0;
      size_reg = SIZE_RESET;
      due_sums.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      // responses first: a query accepted this edge cannot answer this edge
      if (rsp.valid && rsp.ready) begin
        got.range_sum = rsp.range_sum;
        got.status    = rsp.status;
        if (due_sums.size() == 0) begin
          want = '0;
          note_failure("response with nothing due", want, got);
        end else begin
          want = due_sums.pop_front();
          if (got.range_sum !== want.range_sum) note_failure("range_sum mismatch", want, got);
          else if (got.status !== want.status) note_failure("status mismatch", want, got);
        end
      end
      if (req.valid && req.ready)
        predict_request(req.req_type, req.first_index, req.last_index, req.value);
    end
    pending    <= due_sums.size();
    fail_count <= errors;
  end

endmodule

@@ dv/fenwick_range_sum_tree_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_range_sum_tree_core_tb
// Drives increase, build and range-sum transactions into the Fenwick tree
// core across several active sizes, with random gaps on both channels and
// one long response stall; the checker instance predicts and compares.
// ----------------------------------------------------------------------------
module fenwick_range_sum_tree_core_tb;
  import fwt_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CAP         = 1024;
  localparam int MAX_GAP     = 17;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  bit                tx_burst = 1'b0;
  bit                rx_burst = 1'b0;
  bit                long_hold = 1'b0;
  int                live_size = CAP;

  fwt_req_if req_if();
  fwt_rsp_if rsp_if();

  fenwick_range_sum_tree_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fwt_range_sum_checker #(.CAP(CAP)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // response side: per-transaction random hold-off, or one long hold on request
  initial begin
    int hold;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  function automatic logic [INDEX_W-1:0] pick_index();
    if (live_size == 0 || $urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(0, CAP - 1));
    return INDEX_W'($urandom_range(0, live_size - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [TYPE_W-1:0] kind, logic [INDEX_W-1:0] first,
                      logic [INDEX_W-1:0] last, logic [VALUE_W-1:0] value);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.first_index <= first;
    req_if.last_index  <= last;
    req_if.value       <= value;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  // wait until every response is in and the core has finished silent updates
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(int size);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= SIZE_W'(size);
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_size = (size > CAP) ? CAP : size;
  endtask

  task automatic run_random(int count);
    int done;
    int pick;
    int len;
    logic [INDEX_W-1:0] first;
    logic [INDEX_W-1:0] last;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // in-order build run from position 0
        len = $urandom_range(2, 12);
        for (int j = 0; j < len; j++) send(REQ_BUILD, INDEX_W'(j), pick_index(), pick_value());
        done += len;
      end else begin
        first = pick_index();
        if (pick < 45) begin
          send(REQ_INC, first, pick_index(), pick_value());
        end else if (pick < 85) begin
          if (first < live_size && $urandom_range(0, 3) != 0)
            last = INDEX_W'($urandom_range(int'(first), live_size - 1));
          else
            last = pick_index();
          send(REQ_QUERY, first, last, pick_value());
        end else if (pick < 95) begin
          send(REQ_BUILD, first, pick_index(), pick_value());
        end else begin
          send(REQ_UNUSED, first, pick_index(), pick_value());
        end
        done++;
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_INC;
    req_if.first_index <= '0;
    req_if.last_index  <= '0;
    req_if.value       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // build on the cleared store, then queries over edges and reversed ranges
    send(REQ_BUILD, 10'd0, 10'd0, 32'h7fff_ffff);
    send(REQ_BUILD, 10'd1, 10'd0, 32'h8000_0000);
    send(REQ_BUILD, 10'd2, 10'd0, 32'hffff_ffff);
    send(REQ_BUILD, 10'd3, 10'd0, 32'h0000_0000);
    send(REQ_BUILD, 10'd4, 10'd0, 32'h0000_0001);
    send(REQ_BUILD, 10'd5, 10'd0, 32'h1234_5678);
    send(REQ_QUERY, 10'd0, 10'd5, '0);
    send(REQ_QUERY, 10'd0, 10'd0, '0);
    send(REQ_QUERY, 10'd4, 10'd2, '0);
    send(REQ_QUERY, 10'd0, 10'd1023, '0);
    send(REQ_QUERY, 10'd1023, 10'd1023, '0);
    send(REQ_QUERY, 10'd1023, 10'd0, '1);
    send(REQ_INC, 10'd1023, 10'd0, 32'h8000_0000);
    send(REQ_INC, 10'd0, 10'd1023, 32'hffff_ffff);
    send(REQ_INC, 10'd511, 10'd0, 32'd7);
    send(REQ_QUERY, 10'd511, 10'd1023, '0);
    send(REQ_UNUSED, 10'd1023, 10'd1023, '1);

    // indices at and past the active size
    set_size(16);
    send(REQ_INC, 10'd16, 10'd0, 32'd5);
    send(REQ_BUILD, 10'd20, 10'd0, 32'd9);
    send(REQ_QUERY, 10'd0, 10'd16, '0);
    send(REQ_QUERY, 10'd15, 10'd15, '0);

    // empty size: nothing valid
    set_size(0);
    send(REQ_QUERY, 10'd0, 10'd0, '0);
    send(REQ_INC, 10'd0, 10'd0, 32'd3);

    // size above capacity clamps
    set_size(2047);
    send(REQ_QUERY, 10'd1023, 10'd1023, '0);
    send(REQ_INC, 10'd1023, 10'd0, 32'd11);

    run_random(140);

    set_size(1);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    run_random(100);

    // long response stall while requests keep coming back to back
    set_size(37);
    rx_burst  = 1'b0;
    long_hold = 1'b1;
    run_random(150);

    set_size(0);
    tx_burst = 1'b0;
    run_random(60);

    set_size(513);
    rx_burst = 1'b1;
    run_random(170);

    set_size(2);
    rx_burst = 1'b0;
    run_random(80);

    set_size(int'(SIZE_RESET));
    run_random(200);

    set_size(700);
    tx_burst = 1'b1;
    run_random(150);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
